### src/c6502_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_pkg
// shared constants and types for the 6502 execute subset block
// ----------------------------------------------------------------------------
package c6502_pkg;

  localparam int unsigned AddrBits = 16;

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_INX, M_INY
  } mode_e;

  typedef enum logic [4:0] {
    O_ADC, O_AND, O_ASL, O_BIT, O_CMP, O_DEC, O_INC, O_LDA, O_LDX, O_LDY,
    O_STX, O_STY, O_NOP, O_TAX, O_TXA, O_TAY, O_TYA, O_INX, O_DEX, O_INY,
    O_DEY, O_CLC, O_SEC, O_CLI, O_SEI, O_CLV, O_CLD, O_SED
  } op_e;

  typedef struct packed {
    logic  known;
    op_e   op;
    mode_e mode;
  } dec_t;

  function automatic dec_t decode(input logic [7:0] opc);
    dec_t d;
    d.known = 1'b1;
    d.op    = O_NOP;
    d.mode  = M_IMP;
    unique case (opc)
      8'h69: begin d.op = O_ADC; d.mode = M_IMM; end
      8'h65: begin d.op = O_ADC; d.mode = M_ZP;  end
      8'h75: begin d.op = O_ADC; d.mode = M_ZPX; end
      8'h6D: begin d.op = O_ADC; d.mode = M_ABS; end
      8'h7D: begin d.op = O_ADC; d.mode = M_ABX; end
      8'h79: begin d.op = O_ADC; d.mode = M_ABY; end
      8'h61: begin d.op = O_ADC; d.mode = M_INX; end
      8'h71: begin d.op = O_ADC; d.mode = M_INY; end
      8'h29: begin d.op = O_AND; d.mode = M_IMM; end
      8'h25: begin d.op = O_AND; d.mode = M_ZP;  end
      8'h35: begin d.op = O_AND; d.mode = M_ZPX; end
      8'h2D: begin d.op = O_AND; d.mode = M_ABS; end
      8'h3D: begin d.op = O_AND; d.mode = M_ABX; end
      8'h39: begin d.op = O_AND; d.mode = M_ABY; end
      8'h21: begin d.op = O_AND; d.mode = M_INX; end
      8'h31: begin d.op = O_AND; d.mode = M_INY; end
      8'h0A: begin d.op = O_ASL; d.mode = M_ACC; end
      8'h06: begin d.op = O_ASL; d.mode = M_ZP;  end
      8'h16: begin d.op = O_ASL; d.mode = M_ZPX; end
      8'h0E: begin d.op = O_ASL; d.mode = M_ABS; end
      8'h1E: begin d.op = O_ASL; d.mode = M_ABX; end
      8'h24: begin d.op = O_BIT; d.mode = M_ZP;  end
      8'h2C: begin d.op = O_BIT; d.mode = M_ABS; end
      8'hC9: begin d.op = O_CMP; d.mode = M_IMM; end
      8'hC5: begin d.op = O_CMP; d.mode = M_ZP;  end
      8'hD5: begin d.op = O_CMP; d.mode = M_ZPX; end
      8'hCD: begin d.op = O_CMP; d.mode = M_ABS; end
      8'hDD: begin d.op = O_CMP; d.mode = M_ABX; end
      8'hD9: begin d.op = O_CMP; d.mode = M_ABY; end
      8'hC1: begin d.op = O_CMP; d.mode = M_INX; end
      8'hD1: begin d.op = O_CMP; d.mode = M_INY; end
      8'hC6: begin d.op = O_DEC; d.mode = M_ZP;  end
      8'hD6: begin d.op = O_DEC; d.mode = M_ZPX; end
      8'hCE: begin d.op = O_DEC; d.mode = M_ABS; end
      8'hDE: begin d.op = O_DEC; d.mode = M_ABX; end
      8'hE6: begin d.op = O_INC; d.mode = M_ZP;  end
      8'hF6: begin d.op = O_INC; d.mode = M_ZPX; end
      8'hEE: begin d.op = O_INC; d.mode = M_ABS; end
      8'hFE: begin d.op = O_INC; d.mode = M_ABX; end
      8'hA9: begin d.op = O_LDA; d.mode = M_IMM; end
      8'hA5: begin d.op = O_LDA; d.mode = M_ZP;  end
      8'hB5: begin d.op = O_LDA; d.mode = M_ZPX; end
      8'hAD: begin d.op = O_LDA; d.mode = M_ABS; end
      8'hBD: begin d.op = O_LDA; d.mode = M_ABX; end
      8'hB9: begin d.op = O_LDA; d.mode = M_ABY; end
      8'hA1: begin d.op = O_LDA; d.mode = M_INX; end
      8'hB1: begin d.op = O_LDA; d.mode = M_INY; end
      8'hA2: begin d.op = O_LDX; d.mode = M_IMM; end
      8'hA6: begin d.op = O_LDX; d.mode = M_ZP;  end
      8'hB6: begin d.op = O_LDX; d.mode = M_ZPY; end
      8'hAE: begin d.op = O_LDX; d.mode = M_ABS; end
      8'hBE: begin d.op = O_LDX; d.mode = M_ABY; end
      8'hA0: begin d.op = O_LDY; d.mode = M_IMM; end
      8'hA4: begin d.op = O_LDY; d.mode = M_ZP;  end
      8'hB4: begin d.op = O_LDY; d.mode = M_ZPX; end
      8'hAC: begin d.op = O_LDY; d.mode = M_ABS; end
      8'hBC: begin d.op = O_LDY; d.mode = M_ABX; end
      8'h86: begin d.op = O_STX; d.mode = M_ZP;  end
      8'h96: begin d.op = O_STX; d.mode = M_ZPY; end
      8'h8E: begin d.op = O_STX; d.mode = M_ABS; end
      8'h84: begin d.op = O_STY; d.mode = M_ZP;  end
      8'h94: begin d.op = O_STY; d.mode = M_ZPX; end
      8'h8C: begin d.op = O_STY; d.mode = M_ABS; end
      8'hEA: d.op = O_NOP;
      8'hAA: d.op = O_TAX;
      8'h8A: d.op = O_TXA;
      8'hA8: d.op = O_TAY;
      8'h98: d.op = O_TYA;
      8'hE8: d.op = O_INX;
      8'hCA: d.op = O_DEX;
      8'hC8: d.op = O_INY;
      8'h88: d.op = O_DEY;
      8'h18: d.op = O_CLC;
      8'h38: d.op = O_SEC;
      8'h58: d.op = O_CLI;
      8'h78: d.op = O_SEI;
      8'hB8: d.op = O_CLV;
      8'hD8: d.op = O_CLD;
      8'hF8: d.op = O_SED;
      default: d.known = 1'b0;
    endcase
    return d;
  endfunction

endpackage

### src/c6502_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_ram
// single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module c6502_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### src/cpu6502_execute_subset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu6502_execute_subset
// reduced 6502 execution unit with its own byte memory
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_axis   in   tdata: cmd[1:0] address[17:2] data[25:18], pad to 32
// m_axis   out  tdata: a x y status pc read_data unknown_opcode, pad to 64
//
// one memory port; an instruction reads, in this order, the opcode, the
// operand bytes, the pointer bytes and the data. write back shares the
// data step; implied and accumulator forms have an execute step in its place.
// write and unused commands go straight to the result; a read passes S_RD.
// reset clears the registers; memory content is undefined until written.
// a new transaction is taken only after the previous result was taken.
// ----------------------------------------------------------------------------
module cpu6502_execute_subset
  import c6502_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // cmd, address, data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // a, x, y, status, pc, read_data, unknown
);

  localparam logic [3:0] S_IDLE = 4'd0, S_OPC = 4'd1, S_B1 = 4'd2, S_B2 = 4'd3,
    S_P0 = 4'd4, S_P1 = 4'd5, S_DATA = 4'd6, S_EXE = 4'd7, S_RD = 4'd8,
    S_OUT = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, p_q, p_d;
  logic [15:0] pc_q, pc_d, ea_q, ea_d;
  logic [7:0]  b1_q, b1_d, rd_q, rd_d;
  logic        unk_q, unk_d;
  dec_t        dec_q, dec_d;
  logic [15:0] addr_in_q, addr_in_d;

  logic                we;
  logic [AddrBits-1:0] maddr;
  logic [15:0]         maddr16;
  logic [7:0]          wdata, rdata;

  c6502_ram #(.Width(8), .Depth(2 ** AddrBits)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (maddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign maddr = maddr16[AddrBits-1:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {7'd0, unk_q, rd_q, pc_q, p_q, y_q, x_q, a_q};

  logic [8:0] sum;
  logic [7:0] val, res;

  always_comb begin
    state_d = state_q;
    a_d = a_q; x_d = x_q; y_d = y_q; p_d = p_q; pc_d = pc_q;
    ea_d = ea_q; b1_d = b1_q; rd_d = rd_q; unk_d = unk_q; dec_d = dec_q;
    addr_in_d = addr_in_q;
    we = 1'b0; maddr16 = pc_q; wdata = s_axis_tdata[25:18];
    sum = 9'd0; val = rdata; res = 8'd0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          rd_d = 8'd0; unk_d = 1'b0;
          addr_in_d = s_axis_tdata[17:2];
          unique case (cmd_e'(s_axis_tdata[1:0]))
            CMD_EXEC:  begin maddr16 = pc_q; state_d = S_OPC; end
            CMD_WRITE: begin
              maddr16 = s_axis_tdata[17:2]; we = 1'b1; state_d = S_OUT;
            end
            CMD_READ:  begin maddr16 = s_axis_tdata[17:2]; state_d = S_RD; end
            CMD_NONE:  state_d = S_OUT;
          endcase
        end
      end
      S_RD: begin rd_d = rdata; state_d = S_OUT; end
      S_OPC: begin
        dec_d = decode(rdata);
        maddr16 = pc_q + 16'd1;
        if (!dec_d.known) begin
          unk_d = 1'b1; state_d = S_OUT;
        end else begin
          state_d = S_B1;
        end
      end
      S_B1: begin
        b1_d = rdata;
        maddr16 = pc_q + 16'd2;
        state_d = S_DATA;
        unique case (dec_q.mode)
          M_IMM: begin ea_d = pc_q + 16'd1; maddr16 = ea_d; end
          M_ZP:  begin ea_d = {8'd0, rdata}; maddr16 = ea_d; end
          M_ZPX: begin ea_d = {8'd0, rdata + x_q}; maddr16 = ea_d; end
          M_ZPY: begin ea_d = {8'd0, rdata + y_q}; maddr16 = ea_d; end
          M_ABS, M_ABX, M_ABY: state_d = S_B2;
          M_INX: begin
            b1_d = rdata + x_q; maddr16 = {8'd0, b1_d}; state_d = S_P0;
          end
          M_INY: begin maddr16 = {8'd0, rdata}; state_d = S_P0; end
          default: state_d = S_EXE;
        endcase
      end
      S_B2: begin
        unique case (dec_q.mode)
          M_ABX:   ea_d = {rdata, b1_q} + {8'd0, x_q};
          M_ABY:   ea_d = {rdata, b1_q} + {8'd0, y_q};
          default: ea_d = {rdata, b1_q};
        endcase
        maddr16 = ea_d; state_d = S_DATA;
      end
      S_P0: begin
        ea_d = {8'd0, rdata};
        maddr16 = {8'd0, b1_q + 8'd1};
        state_d = S_P1;
      end
      S_P1: begin
        ea_d = {rdata, ea_q[7:0]};
        if (dec_q.mode == M_INY) ea_d = ea_d + {8'd0, y_q};
        maddr16 = ea_d; state_d = S_DATA;
      end
      S_DATA, S_EXE: begin
        state_d = S_OUT;
        maddr16 = ea_q;
        val = (state_q == S_DATA) ? rdata : a_q;
        unique case (dec_q.mode)
          M_IMP, M_ACC: pc_d = pc_q + 16'd1;
          M_ABS, M_ABX, M_ABY: pc_d = pc_q + 16'd3;
          default: pc_d = pc_q + 16'd2;
        endcase
        unique case (dec_q.op)
          O_ADC: begin
            sum = {1'b0, a_q} + {1'b0, val} + {8'd0, p_q[0]};
            res = sum[7:0]; a_d = res;
            p_d[0] = sum[8];
            p_d[6] = (a_q[7] ^ res[7]) & (val[7] ^ res[7]);
          end
          O_AND: begin res = a_q & val; a_d = res; end
          O_ASL: begin
            p_d[0] = val[7]; res = {val[6:0], 1'b0};
            if (dec_q.mode == M_ACC) a_d = res;
            else begin we = 1'b1; wdata = res; end
          end
          O_BIT: begin
            p_d[7] = val[7]; p_d[6] = val[6]; p_d[1] = ((a_q & val) == 8'd0);
          end
          O_CMP: begin p_d[0] = (a_q >= val); res = a_q - val; end
          O_DEC: begin res = val - 8'd1; we = 1'b1; wdata = res; end
          O_INC: begin res = val + 8'd1; we = 1'b1; wdata = res; end
          O_LDA: begin res = val; a_d = res; end
          O_LDX: begin res = val; x_d = res; end
          O_LDY: begin res = val; y_d = res; end
          O_STX: begin we = 1'b1; wdata = x_q; end
          O_STY: begin we = 1'b1; wdata = y_q; end
          O_TAX: begin res = a_q; x_d = res; end
          O_TXA: begin res = x_q; a_d = res; end
          O_TAY: begin res = a_q; y_d = res; end
          O_TYA: begin res = y_q; a_d = res; end
          O_INX: begin res = x_q + 8'd1; x_d = res; end
          O_DEX: begin res = x_q - 8'd1; x_d = res; end
          O_INY: begin res = y_q + 8'd1; y_d = res; end
          O_DEY: begin res = y_q - 8'd1; y_d = res; end
          O_CLC: p_d[0] = 1'b0;
          O_SEC: p_d[0] = 1'b1;
          O_CLI: p_d[2] = 1'b0;
          O_SEI: p_d[2] = 1'b1;
          O_CLV: p_d[6] = 1'b0;
          O_CLD: p_d[3] = 1'b0;
          O_SED: p_d[3] = 1'b1;
          default: ;
        endcase
        unique case (dec_q.op)
          O_ADC, O_AND, O_ASL, O_CMP, O_DEC, O_INC, O_LDA, O_LDX, O_LDY,
          O_TAX, O_TXA, O_TAY, O_TYA, O_INX, O_DEX, O_INY, O_DEY: begin
            p_d[7] = res[7]; p_d[1] = (res == 8'd0);
          end
          default: ;
        endcase
      end
      S_OUT: begin
        maddr16 = addr_in_q;
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0; p_q <= 8'd0; pc_q <= 16'd0;
      unk_q <= 1'b0; rd_q <= 8'd0;
    end else begin
      state_q <= state_d;
      a_q <= a_d; x_q <= x_d; y_q <= y_d; p_q <= p_d; pc_q <= pc_d;
      unk_q <= unk_d; rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ea_q <= ea_d; b1_q <= b1_d; dec_q <= dec_d; addr_in_q <= addr_in_d;
  end

endmodule
